[rtl/clc_pkg.sv]
// Shared widths, class codes and Luhn helpers for the card number classifier.
package clc_pkg;

  localparam int CARD_W      = 54;
  localparam int NUM_DIGITS  = 17;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int LUHN_DIGITS = 16;
  localparam int LUHN_PAIRS  = LUHN_DIGITS / 2;
  localparam int SUM_W       = 8;
  localparam int CLASS_W     = 2;

  localparam logic [CLASS_W-1:0] CLASS_INVALID    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_AMEX       = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_MASTERCARD = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_VISA       = 2'd3;

  typedef struct packed {
    logic [CARD_W-1:0] bin;
    logic [BCD_W-1:0]  bcd;
  } dd_t;

  // Doubled digit with its two decimal digits added: 2d for d < 5, else 2d - 9.
  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [4:0] p;
    begin
      p = {d, 1'b0};
      if (d >= 4'd5) begin
        p = p - 5'd9;
      end
      return p[3:0];
    end
  endfunction

  // True when the sum (at most 144) is a multiple of ten.
  function automatic logic luhn_ok(input logic [SUM_W-1:0] s);
    logic hit;
    begin
      hit = 1'b0;
      for (int k = 0; k <= 14; k++) begin
        if (s == SUM_W'(k * 10)) begin
          hit = 1'b1;
        end
      end
      return hit;
    end
  endfunction

endpackage

[rtl/clc_dd_cell.sv]
// One shift-and-add-3 cell of the binary to decimal conversion chain.
module clc_dd_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vld_in,
  input  clc_pkg::dd_t din,
  output logic         vld_out,
  output clc_pkg::dd_t dout
);
  import clc_pkg::*;

  logic [BCD_W-1:0] adj;
  dd_t              dout_next;

  always_comb begin
    adj = din.bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (din.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = din.bcd[4*i +: 4] + 4'd3;
      end
    end
    // shift the top binary bit into the decimal digits
    dout_next.bcd = {adj[BCD_W-2:0], din.bin[CARD_W-1]};
    dout_next.bin = {din.bin[CARD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[rtl/clc_classify.sv]
// Length check, brand match and Luhn digit sum over the decimal digits.
module clc_classify (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld_in,
  input  logic [clc_pkg::BCD_W-1:0]   bcd,
  output logic                        vld_out,
  output logic [clc_pkg::SUM_W-1:0]   sum,
  output logic [clc_pkg::CLASS_W-1:0] brand
);
  import clc_pkg::*;

  logic [3:0]       dg [0:NUM_DIGITS-1];
  logic [4:0]       pair [0:LUHN_PAIRS-1];
  logic [SUM_W-1:0] sum_next;
  logic [CLASS_W-1:0] brand_next;
  logic len16, len15, len13;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dg[i] = bcd[4*i +: 4];
    end
    for (int j = 0; j < LUHN_PAIRS; j++) begin
      pair[j] = {1'b0, dg[2*j]} + {1'b0, luhn_dbl(dg[2*j+1])};
    end
    sum_next = '0;
    for (int j = 0; j < LUHN_PAIRS; j++) begin
      sum_next = sum_next + SUM_W'(pair[j]);
    end
  end

  always_comb begin
    // seventeen digits is out of range, fourteen is not a card length
    len16 = (dg[16] == 4'd0) && (dg[15] != 4'd0);
    len15 = (dg[16] == 4'd0) && (dg[15] == 4'd0) && (dg[14] != 4'd0);
    len13 = (dg[16] == 4'd0) && (dg[15] == 4'd0) && (dg[14] == 4'd0)
            && (dg[13] == 4'd0) && (dg[12] != 4'd0);
    brand_next = CLASS_INVALID;
    if (len15 && dg[14] == 4'd3 && (dg[13] == 4'd4 || dg[13] == 4'd7)) begin
      brand_next = CLASS_AMEX;
    end else if (len16 && dg[15] == 4'd5 && dg[14] >= 4'd1 && dg[14] <= 4'd5) begin
      brand_next = CLASS_MASTERCARD;
    end else if ((len16 && dg[15] == 4'd4) || (len13 && dg[12] == 4'd4)) begin
      brand_next = CLASS_VISA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum   <= sum_next;
      brand <= brand_next;
    end
  end

endmodule

[rtl/card_number_luhn_classifier_top.sv]
// Card number classifier: decimal conversion chain, classification stage, output buffer.
//
// Takes one card number per cycle while in_ready is high and returns its class
// (0 invalid, 1 amex, 2 mastercard, 3 visa) in request order. A row of 54
// shift-and-add-3 cells turns the binary value into 17 decimal digits, one
// input bit per cell; one stage then checks the length, matches the brand and
// forms the Luhn sum, and the output register applies the mod-10 test. A
// two-entry output buffer lets the chain keep moving while a result waits;
// the chain halts only while both entries are full.
module card_number_luhn_classifier_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [clc_pkg::CARD_W-1:0]  card_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [clc_pkg::CLASS_W-1:0] card_class
);
  import clc_pkg::*;

  logic               en;
  logic               vld_c [0:CARD_W];
  dd_t                dat_c [0:CARD_W];
  logic               vld_a;
  logic [SUM_W-1:0]   sum_a;
  logic [CLASS_W-1:0] brand_a;
  logic [CLASS_W-1:0] res;
  logic               skid_vld;
  logic [CLASS_W-1:0] skid_class;

  assign en       = !skid_vld;
  assign in_ready = en;

  assign vld_c[0]     = in_valid;
  assign dat_c[0].bin = card_value;
  assign dat_c[0].bcd = '0;

  for (genvar g = 0; g < CARD_W; g++) begin : g_chain
    clc_dd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (vld_c[g]),
      .din     (dat_c[g]),
      .vld_out (vld_c[g+1]),
      .dout    (dat_c[g+1])
    );
  end

  clc_classify u_classify (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (vld_c[CARD_W]),
    .bcd     (dat_c[CARD_W].bcd),
    .vld_out (vld_a),
    .sum     (sum_a),
    .brand   (brand_a)
  );

  assign res = luhn_ok(sum_a) ? brand_a : CLASS_INVALID;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      // chain is halted; drain the buffered request first
      if (out_ready) begin
        card_class <= skid_class;
        skid_vld   <= 1'b0;
      end
    end else if (vld_a) begin
      if (!out_valid || out_ready) begin
        out_valid  <= 1'b1;
        card_class <= res;
      end else begin
        skid_vld   <= 1'b1;
        skid_class <= res;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
